// ===== rtl/fmpc_pkg.sv =====
// Package for the first-match packet rule classifier.
// Holds the rule and packet key types, field widths and protocol and action codes.
// Depends on nothing; fmpc_rule_match, the top level and the testbench import it.
`default_nettype none

package fmpc_pkg;

   localparam int ADDR_W   = 32;
   localparam int PREFIX_W = 6;
   localparam int PROTO_W  = 9;
   localparam int PORT_W   = 16;
   localparam int ACTION_W = 2;
   localparam int TAG_W    = 32;
   localparam int INDEX_W  = 6;

   localparam logic [PROTO_W-1:0]  PROTO_TCP  = 9'd6;
   localparam logic [PROTO_W-1:0]  PROTO_UDP  = 9'd17;
   localparam logic [PREFIX_W-1:0] PREFIX_MAX = 6'd32;

   localparam logic CMD_CLASSIFY = 1'b0;
   localparam logic CMD_WRITE    = 1'b1;

   localparam logic [ACTION_W-1:0] ACT_ACCEPT = 2'd0;
   localparam logic [ACTION_W-1:0] ACT_REJECT = 2'd1;
   localparam logic [ACTION_W-1:0] ACT_DROP   = 2'd2;

   typedef struct packed {
      logic [ADDR_W-1:0]   src_addr;
      logic [PREFIX_W-1:0] src_prefix;
      logic [ADDR_W-1:0]   dst_addr;
      logic [PREFIX_W-1:0] dst_prefix;
      logic [PROTO_W-1:0]  proto;
      logic [PORT_W-1:0]   source_port;
      logic [PORT_W-1:0]   dst_port;
      logic [ACTION_W-1:0] action;
   } rule_type;

   typedef struct packed {
      logic [ADDR_W-1:0]  src_addr;
      logic [ADDR_W-1:0]  dst_addr;
      logic [PROTO_W-1:0] proto;
      logic [PORT_W-1:0]  source_port;
      logic [PORT_W-1:0]  dst_port;
   } key_type;

   typedef struct packed {
      logic hit;
      logic drop;
   } match_type;

endpackage

`default_nettype wire

// ===== rtl/fmpc_ram.sv =====
// Generic single-clock RAM with one write port and one registered read port.
// Used for the rule table; depends on nothing.
`default_nettype none

module fmpc_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  wire logic                                   clock,
   input  wire logic                                   wr_en,
   input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]                       wr_data,
   input  wire logic                                   rd_en,
   input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output      logic [WIDTH-1:0]                       rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

// ===== rtl/fmpc_rule_match.sv =====
// Compares one stored rule against a packet key and gives hit and drop.
// Depends on fmpc_pkg for the rule, key and match types.
`default_nettype none

module fmpc_rule_match (
   input  wire fmpc_pkg::rule_type  rule,
   input  wire logic                rule_valid,
   input  wire fmpc_pkg::key_type   key,
   output      fmpc_pkg::match_type result
);
   import fmpc_pkg::*;

   function automatic logic prefix_hit(input logic [ADDR_W-1:0] pkt,
                                       input logic [ADDR_W-1:0] rule_addr,
                                       input logic [PREFIX_W-1:0] len);
      logic [ADDR_W-1:0] mask;
      if (len >= PREFIX_MAX) begin
         mask = '1;
      end else begin
         mask = ~({ADDR_W{1'b1}} >> len);
      end
      return (rule_addr == '0) || (((pkt ^ rule_addr) & mask) == '0);
   endfunction

   logic src_ok;
   logic dst_ok;
   logic proto_ok;
   logic sport_ok;
   logic dport_ok;

   always_comb begin
      src_ok   = prefix_hit(key.src_addr, rule.src_addr, rule.src_prefix);
      dst_ok   = prefix_hit(key.dst_addr, rule.dst_addr, rule.dst_prefix);
      proto_ok = rule.proto[PROTO_W-1] || (key.proto == rule.proto);
      sport_ok = (rule.source_port == '0) || (key.source_port == rule.source_port);
      dport_ok = (rule.dst_port == '0) || (key.dst_port == rule.dst_port);
      result.hit  = rule_valid && src_ok && dst_ok && proto_ok && sport_ok && dport_ok;
      result.drop = (rule.action == ACT_REJECT) || (rule.action == ACT_DROP);
   end

endmodule

`default_nettype wire

// ===== rtl/first_match_packet_rule_classifier_top.sv =====
// Top level of the first-match packet rule classifier: scan control and valid marks.
// Depends on fmpc_pkg, fmpc_ram and fmpc_rule_match.
//
// Usage: an item is taken when start is high and busy is low. With req_cmd set the
// item writes one rule slot (req_entry_index); slots at or above the table size are
// ignored but still acknowledged. A write answers in the next cycle with
// rsp_write_ack set, and busy stays low, so items may follow back to back.
// With req_cmd clear the item classifies a packet: the rule memory is read one
// entry per cycle in index order and the first valid matching rule ends the scan.
// A scan stops at the first hit or else after slot DEPTH - 1, DEPTH being
// NUM_RULES capped at 64, the reachable slots; the single read port of the rule
// memory limits the scan to one entry at a time.
// busy is high from the cycle after a packet is taken until its result shows.
// Each result appears on the rsp_ ports for one cycle, marked by rsp_valid; the
// receiver cannot stall. Reset clears all valid marks and the scan state at once.
`default_nettype none

module first_match_packet_rule_classifier_top #(
   parameter int NUM_RULES = 64
) (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire logic                            start,
   output      logic                            busy,
   input  wire logic                            req_cmd,
   input  wire logic [fmpc_pkg::INDEX_W-1:0]    req_entry_index,
   input  wire logic                            req_entry_valid,
   input  wire logic [fmpc_pkg::ADDR_W-1:0]     req_src_addr,
   input  wire logic [fmpc_pkg::PREFIX_W-1:0]   req_src_prefix,
   input  wire logic [fmpc_pkg::ADDR_W-1:0]     req_dst_addr,
   input  wire logic [fmpc_pkg::PREFIX_W-1:0]   req_dst_prefix,
   input  wire logic [fmpc_pkg::PROTO_W-1:0]    req_proto,
   input  wire logic [fmpc_pkg::PORT_W-1:0]     req_source_port,
   input  wire logic [fmpc_pkg::PORT_W-1:0]     req_dst_port,
   input  wire logic [fmpc_pkg::ACTION_W-1:0]   req_rule_action,
   input  wire logic [fmpc_pkg::TAG_W-1:0]      req_packet_tag,
   output      logic                            rsp_valid,
   output      logic [fmpc_pkg::TAG_W-1:0]      rsp_tag_out,
   output      logic                            rsp_verdict,
   output      logic                            rsp_matched,
   output      logic [fmpc_pkg::INDEX_W-1:0]    rsp_match_slot,
   output      logic                            rsp_write_ack
);
   import fmpc_pkg::*;

   localparam int DEPTH = (NUM_RULES < 64) ? NUM_RULES : 64;
   localparam int IDXW  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int RULE_W = $bits(rule_type);
   localparam logic [IDXW-1:0]    LAST_IDX = IDXW'(DEPTH - 1);
   localparam logic [INDEX_W:0]   DEPTH_LIM = (INDEX_W + 1)'(DEPTH);

   typedef enum logic [1:0] {
      ST_IDLE = 2'b01,
      ST_SCAN = 2'b10
   } state_type;

   state_type         state_ff, state_in;
   logic [DEPTH-1:0]  valid_ff, valid_in;
   logic [IDXW-1:0]   chk_idx_ff, chk_idx_in;
   logic              chk_valid_ff, chk_valid_in;
   key_type           key_ff, key_in;
   logic [TAG_W-1:0]  tag_ff, tag_in;

   logic               rsp_valid_ff, rsp_valid_in;
   logic [TAG_W-1:0]   rsp_tag_ff, rsp_tag_in;
   logic               rsp_verdict_ff, rsp_verdict_in;
   logic               rsp_matched_ff, rsp_matched_in;
   logic [INDEX_W-1:0] rsp_slot_ff, rsp_slot_in;
   logic               rsp_ack_ff, rsp_ack_in;

   logic              accept;
   logic              wr_en;
   logic [IDXW-1:0]   wr_addr;
   rule_type          wr_rule;
   logic              rd_en;
   logic [IDXW-1:0]   rd_addr;
   logic [RULE_W-1:0] rd_data;
   rule_type          rd_rule;
   match_type         match;
   logic              ports_live;

   assign busy    = (state_ff != ST_IDLE);
   assign accept  = start && !busy;
   assign wr_addr = req_entry_index[IDXW-1:0];
   assign wr_en   = accept && (req_cmd == CMD_WRITE)
                    && ({1'b0, req_entry_index} < DEPTH_LIM);
   assign rd_rule = rule_type'(rd_data);
   assign ports_live = (req_proto == PROTO_TCP) || (req_proto == PROTO_UDP);

   always_comb begin
      wr_rule.src_addr    = req_src_addr;
      wr_rule.src_prefix  = req_src_prefix;
      wr_rule.dst_addr    = req_dst_addr;
      wr_rule.dst_prefix  = req_dst_prefix;
      wr_rule.proto       = req_proto;
      wr_rule.source_port = req_source_port;
      wr_rule.dst_port    = req_dst_port;
      wr_rule.action      = req_rule_action;
   end

   fmpc_ram #(
      .WIDTH(RULE_W),
      .DEPTH(DEPTH)
   ) u_rule_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_rule),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   fmpc_rule_match u_rule_match (
      .rule       (rd_rule),
      .rule_valid (chk_valid_ff),
      .key        (key_ff),
      .result     (match)
   );

   always_comb begin
      state_in       = state_ff;
      valid_in       = valid_ff;
      chk_idx_in     = chk_idx_ff;
      chk_valid_in   = chk_valid_ff;
      key_in         = key_ff;
      tag_in         = tag_ff;
      rd_en          = 1'b0;
      rd_addr        = '0;
      rsp_valid_in   = 1'b0;
      rsp_tag_in     = rsp_tag_ff;
      rsp_verdict_in = rsp_verdict_ff;
      rsp_matched_in = rsp_matched_ff;
      rsp_slot_in    = rsp_slot_ff;
      rsp_ack_in     = rsp_ack_ff;

      if (wr_en) begin
         valid_in[wr_addr] = req_entry_valid;
      end

      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               if (req_cmd == CMD_WRITE) begin
                  rsp_valid_in   = 1'b1;
                  rsp_tag_in     = '0;
                  rsp_verdict_in = 1'b0;
                  rsp_matched_in = 1'b0;
                  rsp_slot_in    = '0;
                  rsp_ack_in     = 1'b1;
               end else begin
                  key_in.src_addr    = req_src_addr;
                  key_in.dst_addr    = req_dst_addr;
                  key_in.proto       = req_proto;
                  key_in.source_port = ports_live ? req_source_port : '0;
                  key_in.dst_port    = ports_live ? req_dst_port : '0;
                  tag_in             = req_packet_tag;
                  rd_en              = 1'b1;
                  rd_addr            = '0;
                  chk_idx_in         = '0;
                  chk_valid_in       = valid_ff[0];
                  state_in           = ST_SCAN;
               end
            end
         end
         ST_SCAN: begin
            if (match.hit || (chk_idx_ff == LAST_IDX)) begin
               rsp_valid_in   = 1'b1;
               rsp_tag_in     = tag_ff;
               rsp_verdict_in = match.hit && match.drop;
               rsp_matched_in = match.hit;
               rsp_slot_in    = match.hit ? INDEX_W'(chk_idx_ff) : '0;
               rsp_ack_in     = 1'b0;
               state_in       = ST_IDLE;
            end else begin
               rd_en        = 1'b1;
               rd_addr      = chk_idx_ff + 1'b1;
               chk_idx_in   = rd_addr;
               chk_valid_in = valid_ff[rd_addr];
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         valid_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         valid_ff     <= valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      chk_idx_ff     <= chk_idx_in;
      chk_valid_ff   <= chk_valid_in;
      key_ff         <= key_in;
      tag_ff         <= tag_in;
      rsp_tag_ff     <= rsp_tag_in;
      rsp_verdict_ff <= rsp_verdict_in;
      rsp_matched_ff <= rsp_matched_in;
      rsp_slot_ff    <= rsp_slot_in;
      rsp_ack_ff     <= rsp_ack_in;
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_tag_out    = rsp_tag_ff;
   assign rsp_verdict    = rsp_verdict_ff;
   assign rsp_matched    = rsp_matched_ff;
   assign rsp_match_slot = rsp_slot_ff;
   assign rsp_write_ack  = rsp_ack_ff;

endmodule

`default_nettype wire

// ===== sim/first_match_packet_rule_classifier_top_tb.sv =====
// Self-checking testbench for the first-match packet rule classifier.
// Drives rule writes and packets through the start/busy port, predicts every verdict
// and checks it against the rsp_ ports. Depends on fmpc_pkg and the top level.
`timescale 1ns / 1ps

module first_match_packet_rule_classifier_top_tb;
   import fmpc_pkg::*;

   localparam int NUM_ENTRIES  = 64;
   localparam int RANDOM_ITEMS = 680;
   localparam int QUIET_TAIL   = 100;
   localparam int DRAIN_CYCLES = 80;
   localparam int CYCLE_LIMIT  = 500000;

   localparam logic [PROTO_W-1:0]  PROTO_ANY = 9'd256;
   localparam logic [ACTION_W-1:0] ACT_OTHER = 2'd3;

   typedef struct packed {
      logic                cmd;
      logic [INDEX_W-1:0]  index;
      logic                entry_on;
      logic [ADDR_W-1:0]   src_addr;
      logic [PREFIX_W-1:0] src_prefix;
      logic [ADDR_W-1:0]   dst_addr;
      logic [PREFIX_W-1:0] dst_prefix;
      logic [PROTO_W-1:0]  proto;
      logic [PORT_W-1:0]   source_port;
      logic [PORT_W-1:0]   dst_port;
      logic [ACTION_W-1:0] action;
      logic [TAG_W-1:0]    tag;
   } fw_item_type;

   typedef struct packed {
      logic [TAG_W-1:0]   tag;
      logic               drop;
      logic               hit;
      logic [INDEX_W-1:0] slot;
      logic               ack;
   } verdict_type;

   logic                clock = 1'b0;
   logic                reset = 1'b1;
   logic                start = 1'b0;
   logic                busy;
   logic                req_cmd = 1'b0;
   logic [INDEX_W-1:0]  req_entry_index = '0;
   logic                req_entry_valid = 1'b0;
   logic [ADDR_W-1:0]   req_src_addr = '0;
   logic [PREFIX_W-1:0] req_src_prefix = '0;
   logic [ADDR_W-1:0]   req_dst_addr = '0;
   logic [PREFIX_W-1:0] req_dst_prefix = '0;
   logic [PROTO_W-1:0]  req_proto = '0;
   logic [PORT_W-1:0]   req_source_port = '0;
   logic [PORT_W-1:0]   req_dst_port = '0;
   logic [ACTION_W-1:0] req_rule_action = '0;
   logic [TAG_W-1:0]    req_packet_tag = '0;
   logic                rsp_valid;
   logic [TAG_W-1:0]    rsp_tag_out;
   logic                rsp_verdict;
   logic                rsp_matched;
   logic [INDEX_W-1:0]  rsp_match_slot;
   logic                rsp_write_ack;

   rule_type     rule_mem [NUM_ENTRIES];
   bit           rule_live [NUM_ENTRIES];
   verdict_type  pending_verdicts [$];
   fw_item_type  dir_items [$];
   verdict_type  dir_expect [$];
   bit           dir_known [$];
   int           mismatch_count = 0;
   int           cycle_count = 0;

   first_match_packet_rule_classifier_top #(
      .NUM_RULES(NUM_ENTRIES)
   ) u_top (
      .clock(clock),
      .reset(reset),
      .start(start),
      .busy(busy),
      .req_cmd(req_cmd),
      .req_entry_index(req_entry_index),
      .req_entry_valid(req_entry_valid),
      .req_src_addr(req_src_addr),
      .req_src_prefix(req_src_prefix),
      .req_dst_addr(req_dst_addr),
      .req_dst_prefix(req_dst_prefix),
      .req_proto(req_proto),
      .req_source_port(req_source_port),
      .req_dst_port(req_dst_port),
      .req_rule_action(req_rule_action),
      .req_packet_tag(req_packet_tag),
      .rsp_valid(rsp_valid),
      .rsp_tag_out(rsp_tag_out),
      .rsp_verdict(rsp_verdict),
      .rsp_matched(rsp_matched),
      .rsp_match_slot(rsp_match_slot),
      .rsp_write_ack(rsp_write_ack)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("Regression FAIL");
         $finish;
      end
   end

   task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
      mismatch_count++;
      if (mismatch_count <= 50) begin
         $display("[%0t] mismatch on %s: got 0x%0h, expected 0x%0h", $time, what, got, want);
      end
   endtask

   function automatic bit prefix_hit(logic [ADDR_W-1:0] pkt_addr, logic [ADDR_W-1:0] rule_addr,
                                     logic [PREFIX_W-1:0] len);
      int          bits;
      logic [31:0] mask;
      if (rule_addr == '0) return 1'b1;
      bits = (len > PREFIX_MAX) ? 32 : int'(len);
      if (bits == 0) return 1'b1;
      mask = 32'hFFFF_FFFF << (32 - bits);
      return ((pkt_addr ^ rule_addr) & mask) == '0;
   endfunction

   function automatic verdict_type predict_verdict(fw_item_type it);
      verdict_type       v;
      logic [PORT_W-1:0] sport;
      logic [PORT_W-1:0] dport;
      v = '0;
      if (it.cmd == CMD_WRITE) begin
         rule_live[it.index] = it.entry_on;
         rule_mem[it.index] = '{src_addr: it.src_addr, src_prefix: it.src_prefix,
                                dst_addr: it.dst_addr, dst_prefix: it.dst_prefix,
                                proto: it.proto, source_port: it.source_port,
                                dst_port: it.dst_port, action: it.action};
         v.ack = 1'b1;
         return v;
      end
      sport = it.source_port;
      dport = it.dst_port;
      if (it.proto != PROTO_TCP && it.proto != PROTO_UDP) begin
         sport = '0;
         dport = '0;
      end
      v.tag = it.tag;
      for (int i = 0; i < NUM_ENTRIES; i++) begin
         if (!rule_live[i]) continue;
         if (!prefix_hit(it.src_addr, rule_mem[i].src_addr, rule_mem[i].src_prefix)) continue;
         if (!prefix_hit(it.dst_addr, rule_mem[i].dst_addr, rule_mem[i].dst_prefix)) continue;
         if (rule_mem[i].proto < PROTO_ANY && it.proto != rule_mem[i].proto) continue;
         if (rule_mem[i].source_port != '0 && sport != rule_mem[i].source_port) continue;
         if (rule_mem[i].dst_port != '0 && dport != rule_mem[i].dst_port) continue;
         v.drop = (rule_mem[i].action == ACT_REJECT || rule_mem[i].action == ACT_DROP);
         v.hit  = 1'b1;
         v.slot = INDEX_W'(i);
         return v;
      end
      return v;
   endfunction

   function automatic fw_item_type mk_write(int idx, bit on, logic [31:0] sa, int sp,
                                            logic [31:0] da, int dp, int proto, int sport,
                                            int dport, logic [ACTION_W-1:0] act);
      fw_item_type it;
      it = '0;
      it.cmd = CMD_WRITE;
      it.index = INDEX_W'(idx);
      it.entry_on = on;
      it.src_addr = sa;
      it.src_prefix = PREFIX_W'(sp);
      it.dst_addr = da;
      it.dst_prefix = PREFIX_W'(dp);
      it.proto = PROTO_W'(proto);
      it.source_port = PORT_W'(sport);
      it.dst_port = PORT_W'(dport);
      it.action = act;
      return it;
   endfunction

   function automatic fw_item_type mk_packet(logic [31:0] sa, logic [31:0] da, int proto,
                                             int sport, int dport, logic [31:0] tag);
      fw_item_type it;
      it = '0;
      it.cmd = CMD_CLASSIFY;
      it.src_addr = sa;
      it.dst_addr = da;
      it.proto = PROTO_W'(proto);
      it.source_port = PORT_W'(sport);
      it.dst_port = PORT_W'(dport);
      it.tag = tag;
      return it;
   endfunction

   function automatic verdict_type verdict_of(logic [31:0] tag, bit drop, bit hit, int slot,
                                              bit ack);
      verdict_type v;
      v.tag = tag;
      v.drop = drop;
      v.hit = hit;
      v.slot = INDEX_W'(slot);
      v.ack = ack;
      return v;
   endfunction

   function automatic void add_row(fw_item_type it, bit known, verdict_type want);
      dir_items.push_back(it);
      dir_known.push_back(known);
      dir_expect.push_back(want);
   endfunction

   function automatic fw_item_type random_fields();
      fw_item_type it;
      it.cmd = 1'($urandom_range(0, 1));
      it.index = INDEX_W'($urandom_range(0, NUM_ENTRIES - 1));
      it.entry_on = 1'($urandom_range(0, 1));
      it.src_addr = $urandom();
      it.src_prefix = PREFIX_W'($urandom_range(0, 63));
      it.dst_addr = $urandom();
      it.dst_prefix = PREFIX_W'($urandom_range(0, 63));
      it.proto = PROTO_W'($urandom_range(0, 511));
      it.source_port = PORT_W'($urandom_range(0, 65535));
      it.dst_port = PORT_W'($urandom_range(0, 65535));
      it.action = ACTION_W'($urandom_range(0, 3));
      it.tag = $urandom();
      return it;
   endfunction

   function automatic logic [PREFIX_W-1:0] pick_prefix();
      case ($urandom_range(0, 9))
         0: return '0;
         1: return PREFIX_MAX;
         2: return PREFIX_W'($urandom_range(33, 63));
         default: return PREFIX_W'($urandom_range(1, 32));
      endcase
   endfunction

   function automatic fw_item_type random_rule();
      fw_item_type it;
      it = random_fields();
      it.cmd = CMD_WRITE;
      it.entry_on = ($urandom_range(0, 4) != 0);
      if ($urandom_range(0, 4) == 0) it.src_addr = '0;
      if ($urandom_range(0, 4) == 0) it.dst_addr = '0;
      it.src_prefix = pick_prefix();
      it.dst_prefix = pick_prefix();
      case ($urandom_range(0, 9))
         0: it.proto = PROTO_ANY;
         1: it.proto = PROTO_W'($urandom_range(257, 511));
         2, 3, 4: it.proto = PROTO_TCP;
         5, 6: it.proto = PROTO_UDP;
         default: it.proto = PROTO_W'($urandom_range(0, 255));
      endcase
      if ($urandom_range(0, 2) != 0) it.source_port = '0;
      if ($urandom_range(0, 2) != 0) it.dst_port = '0;
      return it;
   endfunction

   function automatic logic [ADDR_W-1:0] aim_addr(logic [ADDR_W-1:0] rule_addr,
                                                  logic [PREFIX_W-1:0] len,
                                                  logic [ADDR_W-1:0] noise);
      int          bits;
      logic [31:0] mask;
      bits = (len > PREFIX_MAX) ? 32 : int'(len);
      if (rule_addr == '0 || bits == 0) return noise;
      mask = 32'hFFFF_FFFF << (32 - bits);
      return (rule_addr & mask) | (noise & ~mask);
   endfunction

   // Most packets are aimed at one stored rule so that deep slots and each
   // field comparison get exercised; some then get a single bit flipped.
   function automatic fw_item_type random_packet();
      fw_item_type it;
      rule_type    r;
      it = random_fields();
      it.cmd = CMD_CLASSIFY;
      if ($urandom_range(0, 3) != 0) begin
         r = rule_mem[$urandom_range(0, NUM_ENTRIES - 1)];
         it.src_addr = aim_addr(r.src_addr, r.src_prefix, it.src_addr);
         it.dst_addr = aim_addr(r.dst_addr, r.dst_prefix, it.dst_addr);
         if (r.proto < PROTO_ANY) begin
            it.proto = r.proto;
         end else if ($urandom_range(0, 1) == 0) begin
            it.proto = ($urandom_range(0, 1) == 0) ? PROTO_TCP : PROTO_UDP;
         end
         if (r.source_port != '0) it.source_port = r.source_port;
         if (r.dst_port != '0) it.dst_port = r.dst_port;
         if ($urandom_range(0, 9) == 0) begin
            case ($urandom_range(0, 3))
               0: it.src_addr[$urandom_range(0, 31)] ^= 1'b1;
               1: it.dst_addr[$urandom_range(0, 31)] ^= 1'b1;
               2: it.dst_port[$urandom_range(0, 15)] ^= 1'b1;
               default: it.proto[$urandom_range(0, 8)] ^= 1'b1;
            endcase
         end
      end
      return it;
   endfunction

   task automatic send_item(fw_item_type it, int gap, bit known, verdict_type typed);
      verdict_type want;
      if (gap > 0) begin
         start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      start <= 1'b1;
      req_cmd <= it.cmd;
      req_entry_index <= it.index;
      req_entry_valid <= it.entry_on;
      req_src_addr <= it.src_addr;
      req_src_prefix <= it.src_prefix;
      req_dst_addr <= it.dst_addr;
      req_dst_prefix <= it.dst_prefix;
      req_proto <= it.proto;
      req_source_port <= it.source_port;
      req_dst_port <= it.dst_port;
      req_rule_action <= it.action;
      req_packet_tag <= it.tag;
      @(posedge clock);
      while (busy) @(posedge clock);
      want = predict_verdict(it);
      if (known) want = typed;
      pending_verdicts.push_back(want);
   endtask

   always @(posedge clock) begin
      verdict_type want;
      if (!reset && rsp_valid) begin
         if (pending_verdicts.size() == 0) begin
            report_mismatch("result with no item pending", rsp_tag_out, '0);
         end else begin
            want = pending_verdicts.pop_front();
            if (rsp_tag_out !== want.tag) report_mismatch("tag_out", rsp_tag_out, want.tag);
            if (rsp_verdict !== want.drop) report_mismatch("verdict", rsp_verdict, want.drop);
            if (rsp_matched !== want.hit) report_mismatch("matched", rsp_matched, want.hit);
            if (rsp_match_slot !== want.slot) begin
               report_mismatch("match_slot", rsp_match_slot, want.slot);
            end
            if (rsp_write_ack !== want.ack) report_mismatch("write_ack", rsp_write_ack, want.ack);
         end
      end
   end

   initial begin
      verdict_type ack_only;
      verdict_type none;
      fw_item_type it;
      int          gap;
      bit          idle_on;
      ack_only = verdict_of(0, 0, 0, 0, 1);
      none = '0;
      idle_on = 1'b1;
      foreach (rule_mem[j]) rule_mem[j] = '0;

      add_row(mk_packet(32'hFFFF_FFFF, 0, 0, 16'hFFFF, 16'hFFFF, 32'hFFFF_FFFF), 1,
              verdict_of(32'hFFFF_FFFF, 0, 0, 0, 0));
      add_row(mk_write(63, 1, 0, 0, 0, 0, PROTO_ANY, 0, 0, ACT_DROP), 1, ack_only);
      add_row(mk_packet(0, 32'hFFFF_FFFF, 511, 0, 0, 0), 1, verdict_of(0, 1, 1, 63, 0));
      add_row(mk_write(0, 1, 32'hFFFF_FFFF, 32, 0, 0, PROTO_TCP, 16'hFFFF, 0, ACT_ACCEPT), 1,
              ack_only);
      add_row(mk_packet(32'hFFFF_FFFF, 32'h0102_0304, PROTO_TCP, 16'hFFFF, 80, 32'hA5A5_0005),
              1, verdict_of(32'hA5A5_0005, 0, 1, 0, 0));
      add_row(mk_packet(32'hFFFF_FFFF, 32'h0102_0304, 5, 16'hFFFF, 80, 6), 1,
              verdict_of(6, 1, 1, 63, 0));
      add_row(mk_packet(32'hFFFF_FFFF, 32'h0102_0304, PROTO_UDP, 16'hFFFF, 80, 7), 0, none);
      add_row(mk_write(1, 1, 32'h8000_0000, 1, 32'h0A00_0000, 8, PROTO_UDP, 0, 53, ACT_REJECT),
              1, ack_only);
      add_row(mk_packet(32'h8000_0001, 32'h0A0B_0C0D, PROTO_UDP, 1234, 53, 9), 1,
              verdict_of(9, 1, 1, 1, 0));
      add_row(mk_packet(32'h8000_0001, 32'h0B0B_0C0D, PROTO_UDP, 1234, 53, 10), 0, none);
      add_row(mk_packet(32'h8000_0001, 32'h0A0B_0C0D, 1, 1234, 53, 11), 0, none);
      add_row(mk_write(2, 1, 32'h1234_5678, 63, 0, 0, PROTO_ANY, 0, 0, ACT_OTHER), 1, ack_only);
      add_row(mk_packet(32'h1234_5678, 0, PROTO_ANY, 7, 7, 13), 1, verdict_of(13, 0, 1, 2, 0));
      add_row(mk_packet(32'h1234_5679, 0, PROTO_ANY, 7, 7, 14), 0, none);
      add_row(mk_write(3, 0, 0, 0, 0, 0, PROTO_ANY, 0, 0, ACT_DROP), 1, ack_only);
      add_row(mk_write(4, 1, 32'hDEAD_BEEF, 0, 32'hC0A8_0000, 16, PROTO_UDP, 5000, 0,
                       ACT_ACCEPT), 1, ack_only);
      add_row(mk_packet(32'h0101_0101, 32'hC0A8_1234, PROTO_UDP, 5000, 9, 17), 0, none);
      add_row(mk_packet(32'h0101_0101, 32'hC0A8_1234, PROTO_TCP, 5000, 9, 18), 0, none);
      add_row(mk_write(5, 1, 0, 0, 0, 0, 300, 0, 443, ACT_DROP), 1, ack_only);
      add_row(mk_packet(32'h0101_0101, 32'h0202_0202, 50, 443, 443, 20), 0, none);
      add_row(mk_packet(32'h0101_0101, 32'h0202_0202, PROTO_TCP, 443, 443, 21), 0, none);
      add_row(mk_write(63, 0, 0, 0, 0, 0, PROTO_ANY, 0, 0, ACT_DROP), 1, ack_only);
      add_row(mk_packet(32'h0101_0101, 32'h0202_0202, 50, 443, 443, 23), 0, none);
      add_row(mk_packet(32'hFFFF_FFFF, 0, 262, 16'hFFFF, 0, 24), 0, none);

      repeat (5) @(posedge clock);
      reset <= 1'b0;

      foreach (dir_items[k]) begin
         gap = ($urandom_range(0, 2) == 0) ? $urandom_range(1, 18) : 0;
         send_item(dir_items[k], gap, dir_known[k], dir_expect[k]);
      end

      for (int n = 0; n < RANDOM_ITEMS; n++) begin
         if (n % 40 == 0) idle_on = ($urandom_range(0, 2) != 0);
         gap = 0;
         if (idle_on && n < RANDOM_ITEMS - QUIET_TAIL && $urandom_range(0, 2) == 0) begin
            gap = $urandom_range(1, 18);
         end
         if ($urandom_range(0, 99) < ((n < 60) ? 70 : 25)) it = random_rule();
         else it = random_packet();
         send_item(it, gap, 1'b0, none);
      end
      start <= 1'b0;

      while (pending_verdicts.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatch_count == 0 && pending_verdicts.size() == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end

endmodule
